### design/kfc_pkg.sv
// ----------------------------------------------------------------------------
// Keypad calculator package
// Shared word types, key codes, command encoding and divider handshake types.
// ----------------------------------------------------------------------------
package kfc_pkg;

  localparam int WORD_W      = 32;
  localparam int DIV_CNT_W   = $clog2(WORD_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Event codes carried in the op field.
  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_INC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;

  // ASCII codes of the keypad legends.
  localparam logic [6:0] ASCII_ZERO   = 7'd48;
  localparam logic [6:0] ASCII_NINE   = 7'd57;
  localparam logic [6:0] CH_PLUS      = 7'h2B;
  localparam logic [6:0] CH_MINUS     = 7'h2D;
  localparam logic [6:0] CH_STAR      = 7'h2A;
  localparam logic [6:0] CH_SLASH     = 7'h2F;
  localparam logic [6:0] CH_EQUALS    = 7'h3D;
  localparam logic [6:0] CH_CLEAR     = 7'h21;
  localparam logic [6:0] CH_NONE      = 7'h00;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] key_row;
    logic [1:0] key_column;
  } in_word_t;

  typedef struct packed {
    logic               clear_display;
    logic               show_key;
    logic [6:0]         key_char;
    logic               show_result;
    logic signed [31:0] result_value;
    logic               div_by_zero;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DIGIT,
    CMD_OPER,
    CMD_EQUALS,
    CMD_CLEAR,
    CMD_INC,
    CMD_DEC
  } cmd_kind_t;

  typedef enum logic [1:0] {
    OPER_ADD,
    OPER_SUB,
    OPER_MUL,
    OPER_DIV
  } oper_t;

  typedef enum logic [1:0] {
    MODE_FIRST,
    MODE_OPER,
    MODE_SECOND,
    MODE_RESULT
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [6:0] key_char;
    logic [3:0] digit;
    oper_t      oper;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  // Keypad legend by {row, column}.
  function automatic logic [6:0] key_char_of(logic [3:0] idx);
    logic [6:0] ch;
    case (idx)
      4'd0:    ch = 7'h37;
      4'd1:    ch = 7'h38;
      4'd2:    ch = 7'h39;
      4'd3:    ch = CH_SLASH;
      4'd4:    ch = 7'h34;
      4'd5:    ch = 7'h35;
      4'd6:    ch = 7'h36;
      4'd7:    ch = CH_STAR;
      4'd8:    ch = 7'h31;
      4'd9:    ch = 7'h32;
      4'd10:   ch = 7'h33;
      4'd11:   ch = CH_MINUS;
      4'd12:   ch = CH_CLEAR;
      4'd13:   ch = ASCII_ZERO;
      4'd14:   ch = CH_EQUALS;
      4'd15:   ch = CH_PLUS;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

### design/keypad_four_function_calculator.sv
// Path: an accepted word is queued, executed by the back end and then loaded
// into the output register; an equals key on divide first waits for the divider.
// The back end's one-at-a-time sequencer loads each command's word before it
// takes the next, and the bit-serial divider holds it during a division.
// Reset: synchronous on rst_n low; operands, result, mode and operator clear
// to zero and the queue and output register empty.
// ----------------------------------------------------------------------------
// Keypad four-function calculator
// Decodes keypad and increment/decrement words and runs a four-function
// integer calculator, producing one result word per input word.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kfc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output kfc_pkg::out_word_t out_word
);
  import kfc_pkg::*;

  // The front end decodes each word into a command as it is accepted. The
  // two-entry queue lets it keep accepting while the back end is busy with a
  // division or its result word waits on a stalled output.
  logic     push;
  logic     q_full;
  logic     pop;
  logic     head_valid;
  cmd_t     push_cmd;
  cmd_t     head_cmd;

  // The back end owns all calculator state and drives the divider through a
  // request/response pair.
  div_req_t div_req;
  div_rsp_t div_rsp;

  kfc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  kfc_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  kfc_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Each command is executed as it is popped, except a division, which waits for
  // the divider. The finished word is then loaded into the output register,
  // which holds it until the receiver takes it.
  kfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

### design/kfc_front.sv
// ----------------------------------------------------------------------------
// Keypad calculator front end
// Accepts input words and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module kfc_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  kfc_pkg::in_word_t in_word,
  input  logic             q_full,
  output logic             push,
  output kfc_pkg::cmd_t    cmd
);
  import kfc_pkg::*;

  logic [6:0] ch;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign ch       = key_char_of({in_word.key_row, in_word.key_column});

  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_NONE;
    cmd.oper = OPER_ADD;
    case (in_word.op)
      OP_KEY: begin
        cmd.key_char = ch;
        if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
          cmd.kind  = CMD_DIGIT;
          cmd.digit = 4'(ch - ASCII_ZERO);
        end else begin
          case (ch)
            CH_PLUS: begin
              cmd.kind = CMD_OPER;
              cmd.oper = OPER_ADD;
            end
            CH_MINUS: begin
              cmd.kind = CMD_OPER;
              cmd.oper = OPER_SUB;
            end
            CH_STAR: begin
              cmd.kind = CMD_OPER;
              cmd.oper = OPER_MUL;
            end
            CH_SLASH: begin
              cmd.kind = CMD_OPER;
              cmd.oper = OPER_DIV;
            end
            CH_EQUALS: cmd.kind = CMD_EQUALS;
            CH_CLEAR:  cmd.kind = CMD_CLEAR;
            default:   cmd.kind = CMD_NONE;
          endcase
        end
      end
      OP_INC:  cmd.kind = CMD_INC;
      OP_DEC:  cmd.kind = CMD_DEC;
      default: cmd.kind = CMD_NONE;
    endcase
  end

endmodule

### design/kfc_cmd_queue.sv
// ----------------------------------------------------------------------------
// Keypad calculator command queue
// Small FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module kfc_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kfc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output kfc_pkg::cmd_t head_cmd
);
  import kfc_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // The front end stalls on full, so a write never lands on a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command queue written while full");

  // A pop is only issued against a valid head entry.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command queue read while empty");
`endif

endmodule

### design/kfc_divider.sv
// ----------------------------------------------------------------------------
// Keypad calculator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  kfc_pkg::div_req_t req,
  output kfc_pkg::div_rsp_t rsp
);
  import kfc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    rem_r;
  logic [WORD_W-1:0]    quo_r;
  logic [WORD_W-1:0]    dvs_r;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Completion is flagged for one cycle after the last iteration.
      done_r <= !req.start && busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(WORD_W - 1);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // Completion follows the last iteration and never arrives unannounced.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a preceding iteration");
`endif

endmodule

### design/kfc_back.sv
// ----------------------------------------------------------------------------
// Keypad calculator back end
// Executes queued commands on the calculator state and registers the result.
// ----------------------------------------------------------------------------
module kfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  kfc_pkg::cmd_t      head_cmd,
  output logic               pop,
  output kfc_pkg::div_req_t  div_req,
  input  kfc_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output kfc_pkg::out_word_t out_word
);
  import kfc_pkg::*;

  back_state_t       state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  oper_t             oper_r, oper_nxt;
  logic [WORD_W-1:0] first_r, first_nxt;
  logic [WORD_W-1:0] second_r, second_nxt;
  logic [WORD_W-1:0] result_r, result_nxt;
  logic              neg_r, neg_nxt;
  logic              clr_r, clr_nxt;
  logic              show_key_r, show_key_nxt;
  logic [6:0]        char_r, char_nxt;
  logic              show_res_r, show_res_nxt;
  logic              dz_r, dz_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic [WORD_W-1:0] digit_ext;
  logic [WORD_W-1:0] first_x10;
  logic [WORD_W-1:0] second_x10;
  logic [WORD_W-1:0] product;
  logic [WORD_W-1:0] first_mag;
  logic [WORD_W-1:0] second_mag;

  assign digit_ext  = {{(WORD_W - 4){1'b0}}, head_cmd.digit};
  assign first_x10  = (first_r << 3) + (first_r << 1) + digit_ext;
  assign second_x10 = (second_r << 3) + (second_r << 1) + digit_ext;
  assign product    = first_r * second_r;
  assign first_mag  = first_r[WORD_W-1] ? -first_r : first_r;
  assign second_mag = second_r[WORD_W-1] ? -second_r : second_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      mode_r      <= MODE_FIRST;
      oper_r      <= OPER_ADD;
      first_r     <= '0;
      second_r    <= '0;
      result_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      oper_r      <= oper_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      result_r    <= result_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    clr_r      <= clr_nxt;
    show_key_r <= show_key_nxt;
    char_r     <= char_nxt;
    show_res_r <= show_res_nxt;
    dz_r       <= dz_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    oper_nxt      = oper_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    result_nxt    = result_r;
    neg_nxt       = neg_r;
    clr_nxt       = clr_r;
    show_key_nxt  = show_key_r;
    char_nxt      = char_r;
    show_res_nxt  = show_res_r;
    dz_nxt        = dz_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;
    div_req       = '0;

    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          pop          = 1'b1;
          state_nxt    = BK_EMIT;
          clr_nxt      = 1'b0;
          show_key_nxt = 1'b0;
          char_nxt     = head_cmd.key_char;
          show_res_nxt = 1'b0;
          dz_nxt       = 1'b0;
          case (head_cmd.kind)
            CMD_DIGIT: begin
              show_key_nxt = 1'b1;
              case (mode_r)
                MODE_FIRST:  first_nxt = first_x10;
                MODE_OPER: begin
                  second_nxt = digit_ext;
                  mode_nxt   = MODE_SECOND;
                  clr_nxt    = 1'b1;
                end
                MODE_SECOND: second_nxt = second_x10;
                MODE_RESULT: begin
                  first_nxt = digit_ext;
                  mode_nxt  = MODE_FIRST;
                  clr_nxt   = 1'b1;
                end
                default: ;
              endcase
            end
            CMD_OPER: begin
              if (mode_r == MODE_FIRST || mode_r == MODE_OPER) begin
                oper_nxt     = head_cmd.oper;
                mode_nxt     = MODE_OPER;
                clr_nxt      = 1'b1;
                show_key_nxt = 1'b1;
              end
            end
            CMD_EQUALS: begin
              if (mode_r == MODE_SECOND) begin
                mode_nxt     = MODE_RESULT;
                clr_nxt      = 1'b1;
                show_res_nxt = 1'b1;
                case (oper_r)
                  OPER_ADD: result_nxt = first_r + second_r;
                  OPER_SUB: result_nxt = first_r - second_r;
                  OPER_MUL: result_nxt = product;
                  OPER_DIV: begin
                    if (second_r == '0) begin
                      result_nxt = '0;
                      dz_nxt     = 1'b1;
                    end else begin
                      div_req.start    = 1'b1;
                      div_req.dividend = first_mag;
                      div_req.divisor  = second_mag;
                      neg_nxt          = first_r[WORD_W-1] ^ second_r[WORD_W-1];
                      state_nxt        = BK_DIV;
                    end
                  end
                  default: ;
                endcase
              end
            end
            CMD_CLEAR: begin
              mode_nxt   = MODE_FIRST;
              oper_nxt   = OPER_ADD;
              first_nxt  = '0;
              second_nxt = '0;
              result_nxt = '0;
              clr_nxt    = 1'b1;
            end
            CMD_INC: begin
              result_nxt   = result_r + WORD_W'(1);
              clr_nxt      = 1'b1;
              show_res_nxt = 1'b1;
            end
            CMD_DEC: begin
              result_nxt   = result_r - WORD_W'(1);
              clr_nxt      = 1'b1;
              show_res_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          result_nxt = neg_r ? -div_rsp.quotient : div_rsp.quotient;
          state_nxt  = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.clear_display = clr_r;
          out_word_nxt.show_key      = show_key_r;
          out_word_nxt.key_char      = char_r;
          out_word_nxt.show_result   = show_res_r;
          out_word_nxt.result_value  = $signed(result_r);
          out_word_nxt.div_by_zero   = dz_r;
          state_nxt                  = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // A division start always hands control to the wait state.
  a_div_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> state_r == BK_DIV)
    else $error("divider started without entering the wait state");

  // While a quotient is pending the calculator sits in result mode on divide.
  a_div_context: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> mode_r == MODE_RESULT && oper_r == OPER_DIV)
    else $error("division in flight outside an equals on divide");

  // The divider only reports back while the back end is waiting for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == BK_DIV)
    else $error("divider completion outside the wait state");
`endif

endmodule
